@@ hw/rtl/mtt_pkg.sv @@
// Shared widths, mode codes and pipeline payload type for the move-toward-target core.
// No dependencies.
package mtt_pkg;

  localparam int CW         = 32;
  localparam int MW         = CW + 1;
  localparam int SW         = 2 * MW;
  localparam int RW         = MW;
  localparam int FW         = 31;
  localparam int NW         = MW + FW;
  localparam int QW         = FW;
  localparam int REM_W      = RW + 3;
  localparam int SQ_STAGES  = RW;
  localparam int DIV_STAGES = QW;

  typedef enum logic [1:0] {
    MODE_MOVE = 2'd0,
    MODE_SNAP = 2'd1,
    MODE_PARK = 2'd2,
    MODE_STAY = 2'd3
  } mode_t;

  typedef struct packed {
    logic [2:0][CW-1:0] cur;
    logic [2:0][CW-1:0] dst;
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
    logic [FW-1:0]      f;
    mode_t              mode;
  } side_t;

endpackage

@@ hw/rtl/mtt_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, quotient known to fit QW bits.
// Depends on mtt_pkg.
module mtt_div (
  input  logic                   clk,
  input  logic [mtt_pkg::NW-1:0] num_i,
  input  logic [mtt_pkg::RW-1:0] den_i,
  output logic [mtt_pkg::QW-1:0] q_o,
  output logic [mtt_pkg::RW-1:0] rem_o,
  output logic [mtt_pkg::RW-1:0] den_o
);
  import mtt_pkg::*;

  logic [RW-1:0] rem_r [DIV_STAGES];
  logic [QW-1:0] q_r   [DIV_STAGES];
  logic [NW-1:0] num_r [DIV_STAGES];
  logic [RW-1:0] den_r [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [QW-1:0] q_in;
    logic [NW-1:0] num_in;
    logic [RW-1:0] den_in;
    logic [RW:0]   t;
    logic          ge;
    logic [RW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    if (j == 0) begin : g_first
      assign rem_in = num_i[NW-1:QW];
      assign q_in   = '0;
      assign num_in = num_i;
      assign den_in = den_i;
    end else begin : g_rest
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
      assign num_in = num_r[j-1];
      assign den_in = den_r[j-1];
    end

    always_comb begin
      t       = {rem_in, num_in[QW-1-j]};
      ge      = (t >= {1'b0, den_in});
      rem_nxt = ge ? RW'(t - {1'b0, den_in}) : t[RW-1:0];
      q_nxt   = q_in;
      q_nxt[QW-1-j] = ge;
    end

    always_ff @(posedge clk) begin
      rem_r[j] <= rem_nxt;
      q_r[j]   <= q_nxt;
      num_r[j] <= num_in;
      den_r[j] <= den_in;
    end
  end

  assign q_o   = q_r[DIV_STAGES-1];
  assign rem_o = rem_r[DIV_STAGES-1];
  assign den_o = den_r[DIV_STAGES-1];

endmodule

@@ hw/rtl/move_toward_target_3d_core.sv @@
// Top level: one movement step of a 3D point toward a target, signed Q16.16.
// Depends on mtt_pkg and mtt_div.
//
//  channel | handshake            | payload
//  input   | start / busy         | in_cur_x/y/z, in_dst_x/y/z, in_speed
//  result  | out_valid (strobe)   | out_new_x/y/z, out_still_moving
//  config  | cfg_valid / cfg_ready| cfg_data (stop distance)
//
// One request per cycle.
// Depth is set by the 33-stage square root and the three 31-stage dividers.
// busy stays low and cfg_ready stays high; results cannot be stalled.
// Synchronous active-low reset clears valid bits and the stop distance.
module move_toward_target_3d_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [31:0]     in_cur_x,
  input  logic signed [31:0]     in_cur_y,
  input  logic signed [31:0]     in_cur_z,
  input  logic signed [31:0]     in_dst_x,
  input  logic signed [31:0]     in_dst_y,
  input  logic signed [31:0]     in_dst_z,
  input  logic [30:0]            in_speed,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [30:0]            cfg_data,
  output logic                   out_valid,
  output logic signed [31:0]     out_new_x,
  output logic signed [31:0]     out_new_y,
  output logic signed [31:0]     out_new_z,
  output logic                   out_still_moving
);
  import mtt_pkg::*;

  logic [FW-1:0] stop_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      stop_r <= cfg_data;
    end
  end

  // stage 1: differences
  logic               s1_v_r;
  logic [2:0][CW-1:0] s1_cur_r, s1_dst_r;
  logic [2:0][MW-1:0] s1_mag_r;
  logic [2:0]         s1_neg_r;
  logic [FW-1:0]      s1_speed_r;
  logic [2:0][CW-1:0] in_cur, in_dst;
  logic [2:0][MW-1:0] s1_mag_nxt;
  logic [2:0]         s1_neg_nxt;
  logic [MW-1:0]      diff;

  assign in_cur = {in_cur_z, in_cur_y, in_cur_x};
  assign in_dst = {in_dst_z, in_dst_y, in_dst_x};

  always_comb begin
    s1_mag_nxt = '0;
    s1_neg_nxt = '0;
    diff       = '0;
    for (int i = 0; i < 3; i++) begin
      diff = MW'($signed({in_dst[i][CW-1], in_dst[i]}) - $signed({in_cur[i][CW-1], in_cur[i]}));
      s1_neg_nxt[i] = diff[MW-1];
      s1_mag_nxt[i] = diff[MW-1] ? MW'(-diff) : diff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else        s1_v_r <= start && !busy;
    s1_cur_r   <= in_cur;
    s1_dst_r   <= in_dst;
    s1_mag_r   <= s1_mag_nxt;
    s1_neg_r   <= s1_neg_nxt;
    s1_speed_r <= in_speed;
  end

  // stage 2: squares
  logic               s2_v_r;
  logic [2:0][SW-1:0] s2_sq_r;
  logic [2*CW-1:0]    s2_reach2_r;
  logic [2*FW-1:0]    s2_stop2_r;
  logic [2:0][CW-1:0] s2_cur_r, s2_dst_r;
  logic [2:0][MW-1:0] s2_mag_r;
  logic [2:0]         s2_neg_r;
  logic [FW-1:0]      s2_speed_r;
  logic [CW-1:0]      reach;

  assign reach = CW'(s1_speed_r) + CW'(stop_r);

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else        s2_v_r <= s1_v_r;
    for (int i = 0; i < 3; i++) s2_sq_r[i] <= s1_mag_r[i] * s1_mag_r[i];
    s2_reach2_r <= reach * reach;
    s2_stop2_r  <= stop_r * stop_r;
    s2_cur_r    <= s1_cur_r;
    s2_dst_r    <= s1_dst_r;
    s2_mag_r    <= s1_mag_r;
    s2_neg_r    <= s1_neg_r;
    s2_speed_r  <= s1_speed_r;
  end

  // stage 3: sum and decision
  logic          s3_v_r;
  logic [SW-1:0] s3_s_r;
  side_t         s3_side_r;
  logic [SW-1:0] ssum;
  logic          zero, moving, park;
  side_t         s3_side_nxt;

  always_comb begin
    ssum   = s2_sq_r[0] + s2_sq_r[1] + s2_sq_r[2];
    zero   = (ssum == '0);
    moving = !zero && (ssum >= SW'(s2_reach2_r));
    park   = (stop_r != '0) && (ssum > SW'(s2_stop2_r));
    s3_side_nxt.cur = s2_cur_r;
    s3_side_nxt.dst = s2_dst_r;
    s3_side_nxt.mag = s2_mag_r;
    s3_side_nxt.neg = s2_neg_r;
    s3_side_nxt.f   = moving ? s2_speed_r : stop_r;
    if (moving)              s3_side_nxt.mode = MODE_MOVE;
    else if (stop_r == '0)   s3_side_nxt.mode = MODE_SNAP;
    else if (park)           s3_side_nxt.mode = MODE_PARK;
    else                     s3_side_nxt.mode = MODE_STAY;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else        s3_v_r <= s2_v_r;
    s3_s_r    <= ssum;
    s3_side_r <= s3_side_nxt;
  end

  // square root, one root bit per stage
  logic             sq_v_r    [SQ_STAGES];
  logic [SW-1:0]    sq_s_r    [SQ_STAGES];
  logic [REM_W-1:0] sq_rem_r  [SQ_STAGES];
  logic [RW-1:0]    sq_root_r [SQ_STAGES];
  side_t            sq_side_r [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    logic             v_in;
    logic [SW-1:0]    s_in;
    logic [REM_W-1:0] rem_in;
    logic [RW-1:0]    root_in;
    side_t            side_in;
    logic [REM_W-1:0] t, trial, rem_nxt;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in    = s3_v_r;
      assign s_in    = s3_s_r;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = s3_side_r;
    end else begin : g_rest
      assign v_in    = sq_v_r[k-1];
      assign s_in    = sq_s_r[k-1];
      assign rem_in  = sq_rem_r[k-1];
      assign root_in = sq_root_r[k-1];
      assign side_in = sq_side_r[k-1];
    end

    always_comb begin
      t       = {rem_in[REM_W-3:0], s_in[SW-1-2*k -: 2]};
      trial   = {1'b0, root_in, 2'b01};
      ge      = (t >= trial);
      rem_nxt = ge ? t - trial : t;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[k] <= 1'b0;
      else        sq_v_r[k] <= v_in;
      sq_s_r[k]    <= s_in;
      sq_rem_r[k]  <= rem_nxt;
      sq_root_r[k] <= {root_in[RW-2:0], ge};
      sq_side_r[k] <= side_in;
    end
  end

  // numerators
  logic               mu_v_r;
  logic [2:0][NW-1:0] mu_num_r;
  logic [RW-1:0]      mu_len_r;
  side_t              mu_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mu_v_r <= 1'b0;
    else        mu_v_r <= sq_v_r[SQ_STAGES-1];
    for (int i = 0; i < 3; i++) begin
      mu_num_r[i] <= sq_side_r[SQ_STAGES-1].mag[i] * sq_side_r[SQ_STAGES-1].f;
    end
    mu_len_r  <= sq_root_r[SQ_STAGES-1];
    mu_side_r <= sq_side_r[SQ_STAGES-1];
  end

  // dividers with sideband delay
  logic [2:0][QW-1:0] dv_q;
  logic [2:0][RW-1:0] dv_rem, dv_den;
  logic               dv_v_r    [DIV_STAGES];
  side_t              dv_side_r [DIV_STAGES];

  for (genvar i = 0; i < 3; i++) begin : g_div
    mtt_div u_div (
      .clk   (clk),
      .num_i (mu_num_r[i]),
      .den_i (mu_len_r),
      .q_o   (dv_q[i]),
      .rem_o (dv_rem[i]),
      .den_o (dv_den[i])
    );
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j] <= 1'b0;
      else        dv_v_r[j] <= (j == 0) ? mu_v_r : dv_v_r[(j == 0) ? 0 : j-1];
      dv_side_r[j] <= (j == 0) ? mu_side_r : dv_side_r[(j == 0) ? 0 : j-1];
    end
  end

  // rounding
  logic               rd_v_r;
  logic [2:0][CW-1:0] rd_q_r;
  side_t              rd_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) rd_v_r <= 1'b0;
    else        rd_v_r <= dv_v_r[DIV_STAGES-1];
    for (int i = 0; i < 3; i++) begin
      rd_q_r[i] <= CW'(dv_q[i]) +
                   CW'({dv_rem[i], 1'b0} >= {1'b0, dv_den[i]});
    end
    rd_side_r <= dv_side_r[DIV_STAGES-1];
  end

  // apply step and saturate, or take the target (snap) or current position (stay)
  logic               out_v_r;
  logic [2:0][CW-1:0] out_pos_r;
  logic               out_mov_r;
  logic [2:0][CW-1:0] pos_nxt;
  logic signed [CW+1:0] stp, acc;

  always_comb begin
    pos_nxt = '0;
    stp     = '0;
    acc     = '0;
    for (int i = 0; i < 3; i++) begin
      stp = rd_side_r.neg[i] ? -$signed({2'b00, rd_q_r[i]}) : $signed({2'b00, rd_q_r[i]});
      if (rd_side_r.mode == MODE_MOVE) begin
        acc = $signed({{2{rd_side_r.cur[i][CW-1]}}, rd_side_r.cur[i]}) + stp;
      end else begin
        acc = $signed({{2{rd_side_r.dst[i][CW-1]}}, rd_side_r.dst[i]}) - stp;
      end
      if (acc > $signed({3'b000, {(CW-1){1'b1}}}))       pos_nxt[i] = {1'b0, {(CW-1){1'b1}}};
      else if (acc < $signed({3'b111, {(CW-1){1'b0}}}))  pos_nxt[i] = {1'b1, {(CW-1){1'b0}}};
      else                                               pos_nxt[i] = acc[CW-1:0];
      case (rd_side_r.mode)
        MODE_SNAP: pos_nxt[i] = rd_side_r.dst[i];
        MODE_STAY: pos_nxt[i] = rd_side_r.cur[i];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else        out_v_r <= rd_v_r;
    out_pos_r <= pos_nxt;
    out_mov_r <= (rd_side_r.mode == MODE_MOVE);
  end

  assign out_valid        = out_v_r;
  assign out_new_x        = out_pos_r[0];
  assign out_new_y        = out_pos_r[1];
  assign out_new_z        = out_pos_r[2];
  assign out_still_moving = out_mov_r;

`ifndef ASSERT_OFF
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    mu_v_r && (mu_side_r.mode == MODE_MOVE || mu_side_r.mode == MODE_PARK)
      |-> mu_len_r != '0)
    else $error("zero length on a scaled request");

  a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    mu_v_r && (mu_side_r.mode == MODE_MOVE || mu_side_r.mode == MODE_PARK)
      |-> (mu_num_r[0][NW-1:QW] < mu_len_r) && (mu_num_r[1][NW-1:QW] < mu_len_r) &&
          (mu_num_r[2][NW-1:QW] < mu_len_r))
    else $error("quotient overflows divider");

  a_moving_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_still_moving |-> $past(rd_side_r.mode == MODE_MOVE))
    else $error("moving flag without step mode");
`endif

endmodule

@@ bench/tb_move_toward_target_3d_core.sv @@
// Testbench for move_toward_target_3d_core: directed and random move requests checked
// against an in-bench fixed-point predictor, across several stop-distance settings.
// Depends on mtt_pkg and the core RTL.
module tb_move_toward_target_3d_core;
  import mtt_pkg::*;

  localparam logic signed [31:0] CMAX = 32'sh7fffffff;
  localparam logic signed [31:0] CMIN = 32'sh80000000;
  localparam logic [30:0] FMAX = 31'h7fffffff;
  localparam int SETTLE = 90;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        mv;
  } step_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_cur_x = '0, in_cur_y = '0, in_cur_z = '0;
  logic signed [31:0] in_dst_x = '0, in_dst_y = '0, in_dst_z = '0;
  logic [30:0] in_speed = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [30:0] cfg_data = '0;
  logic out_valid;
  logic signed [31:0] out_new_x, out_new_y, out_new_z;
  logic out_still_moving;

  step_res_t pending_steps[$];
  logic [30:0] model_stop = '0;
  int errors = 0;
  int n_req = 0;
  int n_moving = 0;
  int n_arrived = 0;
  bit calm = 1'b0;

  always #2 clk = ~clk;

  move_toward_target_3d_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cur_x(in_cur_x), .in_cur_y(in_cur_y), .in_cur_z(in_cur_z),
    .in_dst_x(in_dst_x), .in_dst_y(in_dst_y), .in_dst_z(in_dst_z),
    .in_speed(in_speed), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_new_x(out_new_x),
    .out_new_y(out_new_y), .out_new_z(out_new_z), .out_still_moving(out_still_moving)
  );

  function automatic logic [63:0] floor_sqrt(logic [67:0] s);
    logic [67:0] r, c;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      c = r | (68'd1 << b);
      if (c * c <= s) r = c;
    end
    return r[63:0];
  endfunction

  function automatic longint scale_comp(longint d, logic [63:0] f, logic [63:0] len);
    logic [63:0] mag, num, q, rem;
    mag = (d < 0) ? 64'(-d) : 64'(d);
    num = mag * f;
    q = num / len;
    rem = num % len;
    if (rem >= len - rem) q++;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sat_coord(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic step_res_t predict_step(logic [2:0][31:0] cur, logic [2:0][31:0] dst,
                                             logic [30:0] spd, logic [30:0] stopd);
    longint c[3], t[3], d[3], r[3];
    logic [63:0] mag, reach, len;
    logic [67:0] s, r2, sd2;
    step_res_t res;
    bit moving;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      c[i] = longint'($signed(cur[i]));
      t[i] = longint'($signed(dst[i]));
      d[i] = t[i] - c[i];
      mag = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
      s = s + {4'b0, mag} * {4'b0, mag};
    end
    reach = {33'b0, spd} + {33'b0, stopd};
    r2 = {4'b0, reach} * {4'b0, reach};
    sd2 = {37'b0, stopd} * {37'b0, stopd};
    moving = (s != 0) && (s >= r2);
    len = floor_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      if (moving) r[i] = sat_coord(c[i] + scale_comp(d[i], {33'b0, spd}, len));
      else if (stopd == 0) r[i] = t[i];
      else if (s > sd2) r[i] = sat_coord(t[i] - scale_comp(d[i], {33'b0, stopd}, len));
      else r[i] = c[i];
    end
    res.x = r[0][31:0];
    res.y = r[1][31:0];
    res.z = r[2][31:0];
    res.mv = moving;
    return res;
  endfunction

  always @(posedge clk) begin
    step_res_t exp_r;
    if (rst_n && cfg_valid && cfg_ready) model_stop <= cfg_data;
    if (rst_n && start && !busy) begin
      pending_steps.push_back(predict_step({in_cur_z, in_cur_y, in_cur_x},
                                           {in_dst_z, in_dst_y, in_dst_x},
                                           in_speed, model_stop));
      n_req++;
    end
    if (rst_n && out_valid) begin
      if (pending_steps.size() == 0) begin
        $error("unexpected result x=%h y=%h z=%h", out_new_x, out_new_y, out_new_z);
        errors++;
      end else begin
        exp_r = pending_steps.pop_front();
        if (out_still_moving) n_moving++; else n_arrived++;
        if (out_new_x !== exp_r.x) begin
          $error("new_x expected %h actual %h", exp_r.x, out_new_x);
          errors++;
        end
        if (out_new_y !== exp_r.y) begin
          $error("new_y expected %h actual %h", exp_r.y, out_new_y);
          errors++;
        end
        if (out_new_z !== exp_r.z) begin
          $error("new_z expected %h actual %h", exp_r.z, out_new_z);
          errors++;
        end
        if (out_still_moving !== exp_r.mv) begin
          $error("still_moving expected %0d actual %0d", exp_r.mv, out_still_moving);
          errors++;
        end
      end
    end
  end

  task automatic send_req(logic signed [31:0] cx, cy, cz, dx, dy, dz, logic [30:0] spd);
    if (!calm && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    start <= 1'b1;
    in_cur_x <= cx; in_cur_y <= cy; in_cur_z <= cz;
    in_dst_x <= dx; in_dst_y <= dy; in_dst_z <= dz;
    in_speed <= spd;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_stop(logic [30:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_snap_and_step;
    send_req(0, 0, 0, 0, 0, 0, 31'd0);
    send_req(CMAX, CMIN, 5, CMAX, CMIN, 5, FMAX);
    send_req(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, FMAX);
    send_req(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, FMAX);
    send_req(CMAX, CMIN, 0, CMIN, CMAX, 0, 31'h1);
    send_req(0, 0, 0, 100, 0, 0, 31'd1000);
    send_req(0, 0, 0, 100, -7, 3, 31'd0);
    send_req(32'sh10000, 0, 0, 0, 32'sh10000, 32'sh10000, 31'h10000);
    send_req(-3, 4, 0, 0, 0, 0, 31'd5);
    send_req(CMAX - 2, CMIN + 2, 0, CMAX, CMIN, 0, 31'h2);
  endtask

  task automatic test_park_and_stay;
    write_stop(31'h30000);
    send_req(0, 0, 0, 32'sh100000, 0, 0, 31'h100000);
    send_req(0, 0, 0, 32'sh20000, 32'sh10000, 0, 31'h10000);
    send_req(7, 7, 7, 7, 7, 7, 31'h1);
    send_req(CMIN, 0, 0, CMIN + 32'sh40000, 0, 0, 31'h0);
    write_stop(FMAX);
    send_req(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, FMAX);
    send_req(CMAX, 0, CMIN, CMIN, 0, CMAX, 31'h0);
    send_req(0, 0, 0, 32'sh1000, -32'sh1000, 1, 31'h5);
  endtask

  function automatic logic signed [31:0] rand_offset();
    int e;
    e = $urandom_range(0, 32);
    if (e == 32) return $urandom;
    return $signed($urandom & ((32'd1 << e) - 1)) * ($urandom_range(0, 1) ? 1 : -1);
  endfunction

  task automatic test_random_moves(logic [30:0] stopd, int count);
    logic signed [31:0] cx, cy, cz;
    logic [30:0] spd;
    write_stop(stopd);
    for (int k = 0; k < count; k++) begin
      cx = $urandom; cy = $urandom; cz = $urandom;
      spd = 31'($urandom & ((32'd1 << $urandom_range(0, 31)) - 1));
      if ($urandom_range(0, 9) == 0)
        send_req(cx, cy, cz, $urandom, $urandom, $urandom, 31'($urandom));
      else
        send_req(cx, cy, cz, cx + rand_offset(), cy + rand_offset(), cz + rand_offset(), spd);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_snap_and_step();
    test_park_and_stay();
    test_random_moves(31'h0, 180);
    calm = 1'b1;
    test_random_moves(31'h1, 180);
    calm = 1'b0;
    test_random_moves(FMAX, 180);
    test_random_moves(31'h10000, 180);
    test_random_moves(31'($urandom), 180);
    drain();
    if (pending_steps.size() != 0) begin
      $error("%0d expected results never arrived", pending_steps.size());
      errors++;
    end
    $display("covered %0d move requests over six stop-distance settings", n_req);
    $display("results: %0d still moving, %0d arrived", n_moving, n_arrived);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
